FILE: hw/rtl/mtc_pkg.sv
// Shared types, codes and helpers of the map tile cache.
`default_nettype none
package mtc_pkg;

  localparam int MaxTilesDefault = 65536;
  localparam int MaxHeldDefault  = 1024;
  localparam int TileNumW        = 16;

  // Stored two-bit tile status codes.
  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_GOOD    = 2'd1;
  localparam logic [1:0] ST_WRITING = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  // Reported status codes.
  localparam logic [2:0] RPT_OFF     = 3'd0;
  localparam logic [2:0] RPT_EMPTY   = 3'd1;
  localparam logic [2:0] RPT_WRITING = 3'd2;
  localparam logic [2:0] RPT_GOOD    = 3'd3;
  localparam logic [2:0] RPT_BAD     = 3'd4;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_WRITE = 2'd1,
    OP_MARK  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    CFG_ORIGIN_WEST   = 3'd0,
    CFG_ORIGIN_NORTH  = 3'd1,
    CFG_TILE_WIDTH    = 3'd2,
    CFG_TILE_HEIGHT   = 3'd3,
    CFG_TILES_ACROSS  = 3'd4,
    CFG_TILES_DOWN    = 3'd5,
    CFG_WINDOW_RADIUS = 3'd6,
    CFG_STORE_LIMIT   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_DROP,
    CELL_APP
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic [TileNumW-1:0]   tile;
  } cell_ctrl_t;

  function automatic logic [2:0] report(input logic [1:0] st);
    logic [2:0] r;
    case (st)
      ST_EMPTY:   r = RPT_EMPTY;
      ST_WRITING: r = RPT_WRITING;
      ST_GOOD:    r = RPT_GOOD;
      default:    r = RPT_BAD;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mtc_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module mtc_div #(
  parameter int NW = 24,
  parameter int DW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quo_o,
  output logic [DW-1:0]      rem_o
);
  localparam int CntW = $clog2(NW + 1);

  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q, den_q;
  logic [CntW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [DW:0]     shifted, diff;
  logic            fits;

  assign shifted = {rem_q, quo_q[NW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(NW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      quo_q <= {quo_q[NW-2:0], fits};
      rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

FILE: hw/rtl/mtc_cell.sv
// One entry of the oldest-first tile list; shifts toward the head on command.
`default_nettype none
module mtc_cell #(
  parameter int IDX = 0,
  parameter int CW  = 11
) (
  input  wire logic                              clk_i,
  input  wire mtc_pkg::cell_ctrl_t               ctrl_i,
  input  wire logic [CW-1:0]                     count_i,
  input  wire logic [mtc_pkg::TileNumW-1:0]      head_i,
  input  wire logic [mtc_pkg::TileNumW-1:0]      nbr_i,
  output logic [mtc_pkg::TileNumW-1:0]           tile_o
);
  import mtc_pkg::*;

  logic [TileNumW-1:0] tile_q, tile_d;
  logic                is_tail, is_free;

  assign is_tail = count_i == CW'(IDX + 1);
  assign is_free = count_i == CW'(IDX);

  always_comb begin
    tile_d = tile_q;
    case (ctrl_i.op)
      // Rotation sends the head entry round to the current tail slot.
      CELL_ROT:  tile_d = is_tail ? head_i : nbr_i;
      CELL_DROP: tile_d = nbr_i;
      CELL_APP:  if (is_free) tile_d = ctrl_i.tile;
      default:   tile_d = tile_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    tile_q <= tile_d;
  end

  assign tile_o = tile_q;
endmodule
`default_nettype wire

FILE: hw/rtl/map_tile_cache_status_and_eviction.sv
// Top level of the map tile cache: tile location, status memory and eviction control.
//
// An item is taken when start_i is high and busy_o is low; its one result beat
// appears on the result ports with done_o high for a single cycle and cannot be
// held off. Queries, marks, off-map items and begin-writes with room in the list
// wait on the bit-serial divider that maps the position to a column and a row
// (one bit per cycle over 24 bits). A begin-write on a full list then walks the
// whole list through the cell chain, one held tile at a time, each waiting on the
// divider that splits its tile number into row and column. After reset, and for
// every clear-all item, the status memory is swept one entry per cycle over all
// MAX_TILES entries (65536 by default), during which busy_o stays high;
// configuration writes are taken at any time.
`default_nettype none
module map_tile_cache_status_and_eviction #(
  parameter int MAX_TILES = mtc_pkg::MaxTilesDefault,
  parameter int MAX_HELD  = mtc_pkg::MaxHeldDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [23:0] easting_i,
  input  wire logic [23:0] northing_i,
  input  wire logic        mark_bad_i,
  input  wire logic [7:0]  camera_col_i,
  input  wire logic [7:0]  camera_row_i,
  output logic             done_o,
  output logic [2:0]       tile_status_o,
  output logic [15:0]      tile_number_o,
  output logic             evicted_valid_o,
  output logic [15:0]      evicted_tile_o,
  output logic             full_error_o,
  output logic [10:0]      held_count_o
);
  import mtc_pkg::*;

  localparam int TW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CW = $clog2(MAX_HELD + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_LOC, S_WR, S_SCAN, S_HWAIT, S_HDEC, S_APP, S_RD, S_OUT
  } state_e;

  // Configuration registers.
  logic [23:0] origin_west_q, origin_north_q;
  logic [15:0] tile_width_q, tile_height_q;
  logic [8:0]  tiles_across_q, tiles_down_q;
  logic [7:0]  window_radius_q;
  logic [10:0] store_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_west_q   <= '0;
      origin_north_q  <= '0;
      tile_width_q    <= 16'd1;
      tile_height_q   <= 16'd1;
      tiles_across_q  <= 9'd1;
      tiles_down_q    <= 9'd1;
      window_radius_q <= '0;
      store_limit_q   <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_WEST:   origin_west_q   <= cfg_data_i;
        CFG_ORIGIN_NORTH:  origin_north_q  <= cfg_data_i;
        CFG_TILE_WIDTH:    tile_width_q    <= cfg_data_i[15:0];
        CFG_TILE_HEIGHT:   tile_height_q   <= cfg_data_i[15:0];
        CFG_TILES_ACROSS:  tiles_across_q  <= cfg_data_i[8:0];
        CFG_TILES_DOWN:    tiles_down_q    <= cfg_data_i[8:0];
        CFG_WINDOW_RADIUS: window_radius_q <= cfg_data_i[7:0];
        CFG_STORE_LIMIT:   store_limit_q   <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero reads as one, counts saturate.
  logic [15:0]   tw_eff, th_eff;
  logic [8:0]    nx_eff, ny_eff;
  logic [CW-1:0] limit_eff;

  always_comb begin
    tw_eff = (tile_width_q == '0) ? 16'd1 : tile_width_q;
    th_eff = (tile_height_q == '0) ? 16'd1 : tile_height_q;
    nx_eff = (tiles_across_q == '0) ? 9'd1 :
             (tiles_across_q > 9'd256) ? 9'd256 : tiles_across_q;
    ny_eff = (tiles_down_q == '0) ? 9'd1 :
             (tiles_down_q > 9'd256) ? 9'd256 : tiles_down_q;
    if (store_limit_q == '0) begin
      limit_eff = CW'(1);
    end else if (int'(store_limit_q) > MAX_HELD) begin
      limit_eff = CW'(MAX_HELD);
    end else begin
      limit_eff = CW'(store_limit_q);
    end
  end

  state_e        state_q;
  logic          accept;
  opcode_e       op_q;
  logic          bad_q, off_q, on_q, room_q, ev_q, full_q, clr_item_q;
  logic [7:0]    cam_col_q, cam_row_q;
  logic [15:0]   tile_q, ev_tile_q;
  logic [CW-1:0] count_q, k_q, n_q;
  logic [TW-1:0] clr_cnt_q;
  logic [1:0]    rd_data_q;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = state_q != S_IDLE;

  // Position to column and row.
  logic        loc_done, row_done;
  logic [23:0] col_quo, row_quo;
  logic [15:0] col_rem, row_rem;

  mtc_div #(.NW(24), .DW(16)) u_col_div (
    .clk_i, .rst_ni,
    .start_i(accept),
    .num_i  ((easting_i >= origin_west_q) ? easting_i - origin_west_q : 24'd0),
    .den_i  (tw_eff),
    .done_o (loc_done),
    .quo_o  (col_quo),
    .rem_o  (col_rem)
  );

  mtc_div #(.NW(24), .DW(16)) u_row_div (
    .clk_i, .rst_ni,
    .start_i(accept),
    .num_i  ((northing_i <= origin_north_q) ? origin_north_q - northing_i : 24'd0),
    .den_i  (th_eff),
    .done_o (row_done),
    .quo_o  (row_quo),
    .rem_o  (row_rem)
  );

  logic [16:0] loc_num;
  logic        loc_on;

  assign loc_num = 17'(row_quo[7:0]) * 17'(nx_eff) + 17'(col_quo[7:0]);
  assign loc_on  = !off_q && (col_quo < 24'(nx_eff)) && (row_quo < 24'(ny_eff)) &&
                   (loc_num < 17'(MAX_TILES));

  // Head entry split into row and column for the window test.
  logic [15:0]         head_tile;
  logic                hdone;
  logic [15:0]         hrow;
  logic [8:0]          hcol;
  logic [15:0]         drow;
  logic [8:0]          dcol;
  logic                outside, drop;

  mtc_div #(.NW(16), .DW(9)) u_head_div (
    .clk_i, .rst_ni,
    .start_i(state_q == S_SCAN),
    .num_i  (head_tile),
    .den_i  (nx_eff),
    .done_o (hdone),
    .quo_o  (hrow),
    .rem_o  (hcol)
  );

  assign drow    = (hrow >= 16'(cam_row_q)) ? hrow - 16'(cam_row_q) : 16'(cam_row_q) - hrow;
  assign dcol    = (hcol >= 9'(cam_col_q)) ? hcol - 9'(cam_col_q) : 9'(cam_col_q) - hcol;
  assign outside = (drow > 16'(window_radius_q)) || (dcol > 9'(window_radius_q));
  assign drop    = !ev_q && outside;

  logic app_ok;
  assign app_ok = room_q && (count_q < CW'(MAX_HELD));

  // Cell chain holding the list, oldest entry in cell zero.
  cell_ctrl_t   ctrl;
  logic [15:0]  cell_tile [MAX_HELD];

  always_comb begin
    ctrl.op   = CELL_HOLD;
    ctrl.tile = tile_q;
    if (state_q == S_HDEC) begin
      ctrl.op = drop ? CELL_DROP : CELL_ROT;
    end else if (state_q == S_APP && app_ok) begin
      ctrl.op = CELL_APP;
    end
  end

  assign head_tile = cell_tile[0];

  for (genvar g = 0; g < MAX_HELD; g++) begin : g_chain
    logic [15:0] nbr;
    if (g == MAX_HELD - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_tile[g+1];
    end
    mtc_cell #(.IDX(g), .CW(CW)) u_cell (
      .clk_i,
      .ctrl_i (ctrl),
      .count_i(count_q),
      .head_i (head_tile),
      .nbr_i  (nbr),
      .tile_o (cell_tile[g])
    );
  end

  // Status memory, one write port and one registered read port.
  logic [1:0]    stat_mem [MAX_TILES];
  logic          mem_we;
  logic [TW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tile_q[TW-1:0];
    mem_wdata = ST_WRITING;
    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = ST_EMPTY;
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_wdata = bad_q ? ST_BAD : ST_GOOD;
      end
      S_HDEC: begin
        mem_we    = drop && (17'(head_tile) < 17'(MAX_TILES));
        mem_waddr = head_tile[TW-1:0];
        mem_wdata = ST_EMPTY;
      end
      S_APP: begin
        mem_we = app_ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stat_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= stat_mem[tile_q[TW-1:0]];
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_CLR;
      clr_cnt_q       <= '0;
      clr_item_q      <= 1'b0;
      op_q            <= OP_QUERY;
      bad_q           <= 1'b0;
      off_q           <= 1'b0;
      on_q            <= 1'b0;
      room_q          <= 1'b0;
      ev_q            <= 1'b0;
      full_q          <= 1'b0;
      cam_col_q       <= '0;
      cam_row_q       <= '0;
      tile_q          <= '0;
      ev_tile_q       <= '0;
      count_q         <= '0;
      k_q             <= '0;
      n_q             <= '0;
      done_o          <= 1'b0;
      tile_status_o   <= RPT_OFF;
      tile_number_o   <= '0;
      evicted_valid_o <= 1'b0;
      evicted_tile_o  <= '0;
      full_error_o    <= 1'b0;
      held_count_o    <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_CLR: begin
          if (clr_cnt_q == TW'(MAX_TILES - 1)) begin
            clr_cnt_q  <= '0;
            clr_item_q <= 1'b0;
            state_q    <= clr_item_q ? S_RD : S_IDLE;
          end else begin
            clr_cnt_q <= clr_cnt_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q      <= opcode_e'(opcode_i);
            bad_q     <= mark_bad_i;
            cam_col_q <= camera_col_i;
            cam_row_q <= camera_row_i;
            off_q     <= (easting_i < origin_west_q) || (northing_i > origin_north_q);
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          if (loc_done) state_q <= S_LOC;
        end
        S_LOC: begin
          tile_q    <= loc_on ? loc_num[15:0] : 16'd0;
          on_q      <= loc_on;
          ev_q      <= 1'b0;
          ev_tile_q <= '0;
          full_q    <= 1'b0;
          room_q    <= count_q < limit_eff;
          if (op_q == OP_CLEAR) begin
            count_q    <= '0;
            clr_item_q <= 1'b1;
            state_q    <= S_CLR;
          end else if (loc_on && op_q == OP_MARK) begin
            state_q <= S_WR;
          end else if (loc_on && op_q == OP_WRITE) begin
            k_q     <= '0;
            n_q     <= count_q;
            state_q <= (count_q >= limit_eff) ? S_SCAN : S_APP;
          end else begin
            state_q <= S_RD;
          end
        end
        S_WR: state_q <= S_RD;
        S_SCAN: state_q <= S_HWAIT;
        S_HWAIT: begin
          if (hdone) state_q <= S_HDEC;
        end
        S_HDEC: begin
          if (drop) begin
            ev_q      <= 1'b1;
            ev_tile_q <= head_tile;
            room_q    <= 1'b1;
            count_q   <= count_q - 1'b1;
          end
          k_q     <= k_q + 1'b1;
          state_q <= (k_q + 1'b1 == n_q) ? S_APP : S_SCAN;
        end
        S_APP: begin
          if (app_ok) begin
            count_q <= count_q + 1'b1;
          end else begin
            full_q <= 1'b1;
          end
          state_q <= S_RD;
        end
        S_RD: state_q <= S_OUT;
        S_OUT: begin
          tile_status_o   <= on_q ? report(rd_data_q) : RPT_OFF;
          tile_number_o   <= on_q ? tile_q : 16'd0;
          evicted_valid_o <= ev_q;
          evicted_tile_o  <= ev_tile_q;
          full_error_o    <= full_q;
          held_count_o    <= 11'(count_q);
          done_o          <= 1'b1;
          state_q         <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The two location dividers run in lockstep.
  assert property (@(posedge clk_i) disable iff (!rst_ni) loc_done == row_done)
    else $error("column and row dividers out of step");

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(MAX_HELD))
    else $error("list count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o |-> !(full_error_o && evicted_valid_o))
    else $error("eviction and full reported on one beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_HDEC && drop) |=> ev_q && $past(count_q) == count_q + 1'b1)
    else $error("eviction did not shorten the list");

  // Unused location remainders.
  logic unused_rem;
  assign unused_rem = ^{col_rem, row_rem};
endmodule
`default_nettype wire
